@@ src/lssd_pkg.sv @@
package lssd_pkg;

  // Operation code carried in the input sideband.
  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_TICK    = 2'd2,
    OP_SERVICE = 2'd3
  } op_t;

  // Frame sequencer phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_LATCH = 2'd2,
    PH_WAIT  = 2'd3
  } phase_t;

  // Controller handshake state.
  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_READ  = 2'd1,
    ST_SHIFT = 2'd2,
    ST_LATCH = 2'd3
  } ctl_state_t;

  localparam logic [1:0] COLOR_RED   = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  localparam logic [2:0] LAST_BIT       = 3'd7;
  localparam logic [7:0] TICK_MAX       = 8'hFF;
  localparam logic [7:0] WAIT_RESET_VAL = 8'd2;

  typedef struct packed {
    logic wr_pixel;
    logic clear_all;
    logic tick;
    logic start;
    logic load_byte;
    logic emit_bit;
    logic emit_latch;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic tick_done;
    logic out_free;
    logic last_bit;
    logic final_byte;
  } sts_t;

endpackage

@@ src/lssd_ctrl.sv @@
module lssd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [1:0]      op,
  input  lssd_pkg::sts_t  sts,
  output lssd_pkg::cmd_t  cmd
);
  import lssd_pkg::*;

  ctl_state_t state, state_next;
  phase_t     phase, phase_next;
  op_t        op_code;
  logic       accept;

  assign op_code = op_t'(op);
  assign accept  = (state == ST_READY) && s_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state and next sequencer phase.
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_READY: begin
        if (accept && op_code == OP_SERVICE) begin
          unique case (phase)
            PH_IDLE: begin
              if (sts.changed) begin
                phase_next = PH_SEND;
              end
            end
            PH_SEND:  state_next = ST_READ;
            PH_LATCH: state_next = ST_LATCH;
            PH_WAIT: begin
              if (sts.tick_done) begin
                phase_next = PH_IDLE;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_SHIFT;
        if (sts.final_byte) begin
          phase_next = PH_LATCH;
        end
      end
      ST_SHIFT: begin
        if (sts.out_free && sts.last_bit) begin
          state_next = ST_READY;
        end
      end
      ST_LATCH: begin
        if (sts.out_free) begin
          state_next = ST_READY;
          phase_next = PH_WAIT;
        end
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_READY: begin
        s_tready = 1'b1;
        if (accept) begin
          unique case (op_code)
            OP_SET:     cmd.wr_pixel  = 1'b1;
            OP_CLEAR:   cmd.clear_all = 1'b1;
            OP_TICK:    cmd.tick      = (phase == PH_WAIT);
            OP_SERVICE: cmd.start     = (phase == PH_IDLE) && sts.changed;
          endcase
        end
      end
      ST_READ:  cmd.load_byte  = 1'b1;
      ST_SHIFT: cmd.emit_bit   = sts.out_free;
      ST_LATCH: cmd.emit_latch = sts.out_free;
    endcase
  end

endmodule

@@ src/lssd_datapath.sv @@
module lssd_datapath #(
  parameter int NUM_PIXELS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  lssd_pkg::cmd_t  cmd,
  output lssd_pkg::sts_t  sts,
  input  logic [31:0]     s_tdata,
  input  logic            cfg_wen,
  input  logic [7:0]      cfg_wdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);
  import lssd_pkg::*;

  localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam logic [AW-1:0] LAST_PIXEL = AW'(NUM_PIXELS - 1);

  logic [23:0]           pix_mem [NUM_PIXELS];
  logic [NUM_PIXELS-1:0] pix_valid;
  logic [23:0]           rd_data;
  logic                  rd_valid;
  logic [AW-1:0]         wr_addr;
  logic                  wr_in_range;
  logic [23:0]           wr_rgb;

  logic                  changed;
  logic [AW-1:0]         send_pixel;
  logic [1:0]            send_color;
  logic [7:0]            ticks;
  logic [7:0]            latch_wait_ticks;
  logic [7:0]            shreg;
  logic [2:0]            bit_cnt;
  logic                  frame_last;
  logic [7:0]            sel_byte;
  logic                  final_byte;

  logic                  out_bit;
  logic                  out_latch;
  logic                  out_fend;
  logic                  out_last;

  assign wr_addr     = s_tdata[AW-1:0];
  assign wr_in_range = {1'b0, s_tdata[7:0]} < 9'(NUM_PIXELS);
  assign wr_rgb      = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

  always_ff @(posedge clk) begin
    if (cmd.wr_pixel && wr_in_range) begin
      pix_mem[wr_addr] <= wr_rgb;
    end
    rd_data <= pix_mem[send_pixel];
  end

  // An entry whose valid bit is low reads as black.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      pix_valid <= '0;
    end else if (cmd.wr_pixel && wr_in_range) begin
      pix_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= pix_valid[send_pixel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_wait_ticks <= WAIT_RESET_VAL;
    end else if (cfg_wen) begin
      latch_wait_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
    end else if (cmd.wr_pixel || cmd.clear_all) begin
      changed <= 1'b1;
    end else if (cmd.start) begin
      changed <= 1'b0;
    end
  end

  assign final_byte = (send_color == COLOR_BLUE) && (send_pixel == LAST_PIXEL);

  always_comb begin
    unique case (send_color)
      COLOR_RED:   sel_byte = rd_data[23:16];
      COLOR_GREEN: sel_byte = rd_data[15:8];
      default:     sel_byte = rd_data[7:0];
    endcase
    if (!rd_valid) begin
      sel_byte = '0;
    end
  end

  // Frame position advances as each byte is loaded for shifting.
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      send_pixel <= '0;
      send_color <= COLOR_RED;
    end else if (cmd.load_byte) begin
      if (send_color == COLOR_BLUE) begin
        send_color <= COLOR_RED;
        send_pixel <= (send_pixel == LAST_PIXEL) ? '0 : send_pixel + 1'b1;
      end else begin
        send_color <= send_color + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt    <= '0;
      frame_last <= 1'b0;
    end else if (cmd.load_byte) begin
      bit_cnt    <= '0;
      frame_last <= final_byte;
    end else if (cmd.emit_bit) begin
      bit_cnt    <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      shreg <= sel_byte;
    end else if (cmd.emit_bit) begin
      shreg <= {shreg[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit_latch) begin
      ticks <= '0;
    end else if (cmd.tick && ticks != TICK_MAX) begin
      ticks <= ticks + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_bit || cmd.emit_latch) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_bit) begin
      out_bit   <= shreg[7];
      out_latch <= 1'b0;
      out_fend  <= frame_last && (bit_cnt == LAST_BIT);
      out_last  <= (bit_cnt == LAST_BIT);
    end else if (cmd.emit_latch) begin
      out_bit   <= 1'b0;
      out_latch <= 1'b1;
      out_fend  <= 1'b0;
      out_last  <= 1'b1;
    end
  end

  assign m_tdata = {5'b0, out_fend, out_latch, out_bit};
  assign m_tlast = out_last;

  assign sts.changed    = changed;
  assign sts.tick_done  = (ticks >= latch_wait_ticks);
  assign sts.out_free   = !m_tvalid || m_tready;
  assign sts.last_bit   = (bit_cnt == LAST_BIT);
  assign sts.final_byte = final_byte;

endmodule

@@ src/led_strip_shift_driver_unit.sv @@
// Channel   Dir  Signals                         Contents
// input     in   s_tvalid s_tready s_tdata s_tuser  one command beat (set, clear, tick, service)
// output    out  m_tvalid m_tready m_tdata m_tlast  one strip bit or the latch marker
// config    in   cfg_wen cfg_wdata                  latch wait in millisecond ticks
//
// Set, clear and tick beats are accepted in the ready state, which they keep. A
// service beat in the sending phase reads the pixel store at its acceptance,
// loads the shifter on the next cycle and then shifts its byte out one bit a
// cycle through the output register; a stall on m_tready holds the shifter in
// place, and the next beat is not taken until the last bit is issued. The latch
// beat issues the latch marker once the output register is free. Reset blacks
// the whole store at once through per-pixel valid bits, so no clearing pass is needed.
module led_strip_shift_driver_unit #(
  parameter int NUM_PIXELS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // led_index, red, green, blue
  input  logic [1:0]  s_tuser,    // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // data_bit, is_latch, frame_end, zero fill
  output logic        m_tlast,    // last result of the service beat
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata   // latch_wait_ticks
);
  import lssd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns the handshake and the frame phase; every data
  // movement it orders is carried out by the datapath below.
  lssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the pixel store, frame position, bit shifter,
  // tick counter and the output register.
  lssd_datapath #(
    .NUM_PIXELS (NUM_PIXELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
